// ===== sv/rpn_pkg.sv =====
package rpn_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_SUB    = 3'd2,
        CMD_MUL    = 3'd3,
        CMD_DIV    = 3'd4,
        CMD_MOD    = 3'd5,
        CMD_FINISH = 3'd6,
        CMD_UNK    = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [7:0]         depth;
        logic [1:0]         underflows;
        logic               overflow;
        logic               zero_divisor;
        logic               unknown_command;
    } out_item_t;

    // front part's classified beat
    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] value;
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POPB,
        ST_POPA,
        ST_MUL,
        ST_DIVINIT,
        ST_DIVRUN,
        ST_DIVFIX,
        ST_WRITE,
        ST_TOP,
        ST_TOPRD,
        ST_OUT
    } state_t;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage

// ===== sv/rpn_front.sv =====
module rpn_front (
    input  logic             clk,
    input  logic             rst_n,
    input  rpn_pkg::in_item_t in_item,
    input  logic             push,
    output logic             full,
    output rpn_pkg::op_t     op,
    output logic             op_valid,
    input  logic             op_take
);
    import rpn_pkg::*;

    // two-entry queue between front and back
    op_t        q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       do_push, do_pop;

    assign full     = cnt_reg == 2'd2;
    assign do_push  = push && !full;
    assign do_pop   = op_take && op_valid;
    assign op_valid = cnt_reg != 2'd0;
    assign op       = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        rd_next  = rd_reg ^ do_pop;
        wr_next  = wr_reg ^ do_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    // classify: only push keeps its operand
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg].cmd   <= cmd_t'(in_item.command);
            q_reg[wr_reg].value <= (in_item.command == CMD_PUSH) ? in_item.value : '0;
        end
    end
endmodule

// ===== sv/rpn_back.sv =====
module rpn_back #(
    parameter int STACK_DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::op_t      op,
    input  logic              op_valid,
    output logic              op_take,
    output rpn_pkg::out_item_t result,
    output logic              empty,
    input  logic              pop
);
    import rpn_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] mem [STACK_DEPTH];
    logic signed [31:0] rdata_reg;

    state_t state_reg, state_next;
    logic [PW-1:0] sp_reg, sp_next;
    op_t    op_reg;
    logic signed [31:0] a_reg, a_next, b_reg, b_next;
    logic signed [31:0] res_reg, res_next;
    logic [1:0] unf_reg, unf_next;
    logic ovf_reg, ovf_next, zd_reg, zd_next;
    logic fin_reg, fin_next;
    logic signed [63:0] prod_reg;
    // divider: unsigned restoring, 48-bit dividend; also gives the integer remainder for mod
    logic [47:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic        neg_reg, neg_next;
    logic        out_v_reg, out_v_next;
    out_item_t   out_reg, out_next;

    logic        mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic signed [31:0] mem_wd;
    logic [32:0] trial;
    logic signed [63:0] pshift;
    logic signed [48:0] qs;
    logic signed [15:0] ia, ib;

    assign empty  = !out_v_reg;
    assign result = out_reg;

    // stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rdata_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
        if (op_take)
            op_reg <= op;
    end

    function automatic logic signed [31:0] sat(input logic signed [64:0] v);
        if (v > 65'(SAT_MAX))
            return SAT_MAX;
        else if (v < 65'(SAT_MIN))
            return SAT_MIN;
        else
            return v[31:0];
    endfunction

    always_comb
    begin
        trial  = {rem_reg, quo_reg[47]} - {1'b0, dvs_reg};
        pshift = prod_reg >>> 16;
        qs     = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        ia     = a_reg[31] ? -16'(-a_reg >>> 16) : a_reg[31:16];
        ib     = b_reg[31] ? -16'(-b_reg >>> 16) : b_reg[31:16];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (op_valid)
                        begin
                            case (op.cmd)
                                CMD_PUSH: state_next = ST_WRITE;
                                CMD_UNK:  state_next = ST_TOP;
                                default:  state_next = ST_POPB;
                            endcase
                        end
            ST_POPB:    begin
                            if (op_reg.cmd == CMD_FINISH)
                                state_next = ST_OUT;
                            else
                                state_next = ST_POPA;
                        end
            ST_POPA:    begin
                            case (op_reg.cmd)
                                CMD_MUL: state_next = ST_MUL;
                                CMD_DIV: state_next = (b_reg == '0) ? ST_TOP : ST_DIVINIT;
                                CMD_MOD: state_next = (ib == '0) ? ST_TOP : ST_DIVINIT;
                                default: state_next = ST_WRITE;
                            endcase
                        end
            ST_MUL:     state_next = ST_WRITE;
            ST_DIVINIT: state_next = ST_DIVRUN;
            ST_DIVRUN:  if (dcnt_reg == 6'd47) state_next = ST_DIVFIX;
            ST_DIVFIX:  state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_TOP;
            ST_TOP:     state_next = ST_TOPRD;
            ST_TOPRD:   state_next = ST_OUT;
            ST_OUT:     if (!out_v_reg || pop) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_take    = 1'b0;
        sp_next    = sp_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        unf_next   = unf_reg;
        ovf_next   = ovf_reg;
        zd_next    = zd_reg;
        fin_next   = fin_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        out_v_next = out_v_reg && !pop;
        out_next   = out_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wa     = sp_reg[AW-1:0];
        mem_ra     = AW'(sp_reg - PW'(1));
        mem_wd     = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    op_take  = 1'b1;
                    unf_next = '0;
                    ovf_next = 1'b0;
                    zd_next  = 1'b0;
                    fin_next = 1'b0;
                    res_next = op.value;
                    if (op.cmd != CMD_PUSH && op.cmd != CMD_UNK)
                        mem_re = sp_reg != '0;
                end
            end
            ST_POPB:
            begin
                if (sp_reg != '0)
                begin
                    b_next  = rdata_reg;
                    sp_next = sp_reg - PW'(1);
                    mem_ra  = AW'(sp_reg - PW'(2));
                    mem_re  = sp_reg != PW'(1);
                end
                else
                begin
                    b_next   = '0;
                    unf_next = 2'd1;
                end
                fin_next = op_reg.cmd == CMD_FINISH;
                res_next = (sp_reg != '0) ? rdata_reg : '0;
            end
            ST_POPA:
            begin
                if (op_reg.cmd == CMD_DIV && b_reg == '0)
                    zd_next = 1'b1;
                else if (op_reg.cmd == CMD_MOD && ib == '0)
                    zd_next = 1'b1;
                else if (sp_reg != '0)
                begin
                    a_next  = rdata_reg;
                    sp_next = sp_reg - PW'(1);
                end
                else
                begin
                    a_next   = '0;
                    unf_next = unf_reg + 2'd1;
                end
            end
            ST_MUL: ;
            ST_DIVINIT:
            begin
                if (op_reg.cmd == CMD_MOD)
                begin
                    // integer parts; the remainder takes the sign of the dividend
                    neg_next = ia[15];
                    quo_next = {32'd0, (ia[15] ? 16'(-ia) : ia)};
                    dvs_next = {16'd0, (ib[15] ? 16'(-ib) : ib)};
                end
                else
                begin
                    neg_next = a_reg[31] ^ b_reg[31];
                    quo_next = {(a_reg[31] ? -a_reg : a_reg), 16'd0};
                    dvs_next = b_reg[31] ? -b_reg : b_reg;
                end
                rem_next  = '0;
                dcnt_next = '0;
            end
            ST_DIVRUN:
            begin
                // one quotient bit a cycle
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[47]};
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
            end
            ST_DIVFIX:
            begin
                if (op_reg.cmd == CMD_MOD)
                    res_next = {(neg_reg ? -rem_reg[15:0] : rem_reg[15:0]), 16'd0};
                else
                    res_next = sat(65'(qs));
            end
            ST_WRITE:
            begin
                case (op_reg.cmd)
                    CMD_PUSH: res_next = op_reg.value;
                    CMD_ADD:  res_next = sat(65'(a_reg) + 65'(b_reg));
                    CMD_SUB:  res_next = sat(65'(a_reg) - 65'(b_reg));
                    CMD_MUL:  res_next = sat(65'(pshift));
                    default:  res_next = res_reg;
                endcase
                if (sp_reg < PW'(STACK_DEPTH))
                begin
                    mem_we  = 1'b1;
                    mem_wd  = res_next;
                    sp_next = sp_reg + PW'(1);
                end
                else
                    ovf_next = 1'b1;
            end
            ST_TOP:
                mem_re = sp_reg != '0;
            ST_TOPRD:
                res_next = (sp_reg != '0) ? rdata_reg : '0;
            ST_OUT:
            begin
                // wait here while the previous result beat is still unread
                if (!out_v_reg || pop)
                begin
                    out_v_next = 1'b1;
                    out_next.top_value       = res_reg;
                    out_next.depth           = 8'(sp_reg);
                    out_next.underflows      = unf_reg;
                    out_next.overflow        = ovf_reg;
                    out_next.zero_divisor    = zd_reg;
                    out_next.unknown_command = op_reg.cmd == CMD_UNK;
                end
            end
            default: ;
        endcase
        if (fin_reg)
            res_next = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            out_v_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            out_v_reg <= out_v_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        unf_reg  <= unf_next;
        ovf_reg  <= ovf_next;
        zd_reg   <= zd_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        dcnt_reg <= dcnt_next;
        neg_reg  <= neg_next;
        out_reg  <= out_next;
    end
endmodule

// ===== sv/rpn_stack_calculator.sv =====
// Reverse-Polish calculator on signed Q16.16 values with saturating results.
// Each input beat is a push or an operator; every beat gives one result beat
// with the new top, depth and error flags. Div and mod use the bit-serial
// divider that makes one of 48 quotient bits a cycle. A two-beat queue in
// front lets the producer keep pushing while an item is being worked on, and
// the back end only waits if the previous result beat is still unread.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::in_item_t  in_item,
    input  logic               push,
    output logic               full,
    output rpn_pkg::out_item_t out_item,
    output logic               empty,
    input  logic               pop
);
    import rpn_pkg::*;

    op_t  op;
    logic op_valid, op_take;

    rpn_front u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .op(op), .op_valid(op_valid), .op_take(op_take)
    );

    rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .op(op), .op_valid(op_valid), .op_take(op_take),
        .result(out_item), .empty(empty), .pop(pop)
    );
endmodule

// ===== test/tb_rpn_stack_calculator.sv =====
module tb_rpn_stack_calculator;
    import rpn_pkg::*;

    localparam int DEPTH     = 128;
    localparam int MAX_CYCLE = 900000;

    logic      clk;
    logic      rst_n;
    in_item_t  in_item;
    logic      push;
    logic      full;
    out_item_t out_item;
    logic      empty;
    logic      pop;

    // predictor state
    logic signed [31:0] calc_stack [DEPTH];
    int                 calc_sp;
    out_item_t          expected_results [$];

    int  errors;
    int  cycle_count;
    bit  hold_results;
    int  hold_cycles;

    rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .push     (push),
        .full     (full),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [31:0] saturate(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return SAT_MAX;
        if (v < -64'sh8000_0000)
            return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] take_entry(ref int empties);
        if (calc_sp > 0)
        begin
            calc_sp--;
            return calc_stack[calc_sp];
        end
        empties++;
        return 32'sd0;
    endfunction

    // work out the result of one command and update the model stack
    function automatic out_item_t compute_result(in_item_t it);
        out_item_t          r;
        int                 empties;
        logic signed [31:0] a, b, top, ia, ib;
        logic signed [63:0] wide;
        bit                 finished;
        empties  = 0;
        finished = 0;
        top      = 0;
        r        = '0;
        case (cmd_t'(it.command))
            CMD_PUSH:
                if (calc_sp < DEPTH)
                begin
                    calc_stack[calc_sp] = it.value;
                    calc_sp++;
                end
                else
                    r.overflow = 1'b1;
            CMD_ADD, CMD_SUB, CMD_MUL:
            begin
                b = take_entry(empties);
                a = take_entry(empties);
                if (cmd_t'(it.command) == CMD_ADD)
                    wide = 64'(a) + 64'(b);
                else if (cmd_t'(it.command) == CMD_SUB)
                    wide = 64'(a) - 64'(b);
                else
                    wide = (64'(a) * 64'(b)) >>> 16;
                calc_stack[calc_sp] = saturate(wide);
                calc_sp++;
            end
            CMD_DIV:
            begin
                b = take_entry(empties);
                if (b == 0)
                    r.zero_divisor = 1'b1;
                else
                begin
                    a = take_entry(empties);
                    wide = (64'(a) <<< 16) / 64'(b);
                    calc_stack[calc_sp] = saturate(wide);
                    calc_sp++;
                end
            end
            CMD_MOD:
            begin
                b  = take_entry(empties);
                ib = b / 32'sd65536;
                if (ib == 0)
                    r.zero_divisor = 1'b1;
                else
                begin
                    a  = take_entry(empties);
                    ia = a / 32'sd65536;
                    wide = 64'(ia % ib) <<< 16;
                    calc_stack[calc_sp] = saturate(wide);
                    calc_sp++;
                end
            end
            CMD_FINISH:
            begin
                top      = take_entry(empties);
                finished = 1;
            end
            default:
                r.unknown_command = 1'b1;
        endcase
        if (!finished)
            top = (calc_sp > 0) ? calc_stack[calc_sp - 1] : 32'sd0;
        r.top_value  = top;
        r.depth      = calc_sp[7:0];
        r.underflows = empties[1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        errors++;
    endtask

    // send one beat, after a random gap; push stays high between back-to-back beats
    task automatic send_item(cmd_t c, logic signed [31:0] v);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.command <= c;
        in_item.value   <= v;
        push            <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_results.push_back(compute_result('{command: c, value: v}));
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
            2:       return $urandom_range(0, 65535);
            3:       return SAT_MAX - $urandom_range(0, 3);
            4:       return SAT_MIN + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
        endcase
    endfunction

    // result side: random pops, checking each accepted beat
    initial
    begin
        out_item_t want;
        int        gap;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (hold_results)
            begin
                gap          = gap + hold_cycles;
                hold_results = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $display("unexpected result beat at cycle %0d", cycle_count);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.top_value !== want.top_value)
                    report_mismatch("top_value", out_item.top_value, want.top_value);
                if (out_item.depth !== want.depth)
                    report_mismatch("depth", 32'(out_item.depth), 32'(want.depth));
                if (out_item.underflows !== want.underflows)
                    report_mismatch("underflows", 32'(out_item.underflows),
                                    32'(want.underflows));
                if (out_item.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(out_item.overflow),
                                    32'(want.overflow));
                if (out_item.zero_divisor !== want.zero_divisor)
                    report_mismatch("zero_divisor", 32'(out_item.zero_divisor),
                                    32'(want.zero_divisor));
                if (out_item.unknown_command !== want.unknown_command)
                    report_mismatch("unknown_command", 32'(out_item.unknown_command),
                                    32'(want.unknown_command));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("rpn_stack_calculator test failed");
            $finish;
        end
    end

    // extremes, each operator, underflow, zero divisors, unknown token
    task automatic test_directed();
        send_item(CMD_FINISH, 32'sd0);
        send_item(CMD_ADD, 32'sd0);
        send_item(CMD_PUSH, SAT_MAX);
        send_item(CMD_PUSH, SAT_MAX);
        send_item(CMD_ADD, 32'sd0);
        send_item(CMD_PUSH, SAT_MIN);
        send_item(CMD_SUB, 32'sd0);
        send_item(CMD_PUSH, SAT_MIN);
        send_item(CMD_MUL, 32'sd0);
        send_item(CMD_PUSH, -32'sd3 <<< 16);
        send_item(CMD_DIV, 32'sd0);
        send_item(CMD_PUSH, 32'sd0);
        send_item(CMD_DIV, 32'sd0);
        send_item(CMD_PUSH, 32'sd7 <<< 15);
        send_item(CMD_MOD, 32'sd0);
        send_item(CMD_PUSH, -32'sd7 <<< 16);
        send_item(CMD_PUSH, 32'sd3 <<< 16);
        send_item(CMD_MOD, 32'sd0);
        send_item(CMD_PUSH, -32'sd1);
        send_item(CMD_MUL, 32'sd0);
        send_item(CMD_UNK, 32'sd5);
        send_item(CMD_FINISH, 32'sd0);
        send_item(CMD_FINISH, 32'sd0);
        send_item(CMD_MOD, 32'sd0);
    endtask

    // fill to overflow while results are held back, then drain
    task automatic test_full_stack();
        hold_cycles  = 400;
        hold_results = 1;
        repeat (DEPTH + 3)
            send_item(CMD_PUSH, random_value());
        repeat (DEPTH + 2)
            send_item(($urandom_range(0, 1) == 0) ? CMD_FINISH : CMD_ADD, 32'sd0);
    endtask

    // mostly well-formed expressions on a shallow stack, some noise
    task automatic test_random();
        cmd_t c;
        repeat (750)
        begin
            if ($urandom_range(0, 9) == 0)
                c = cmd_t'($urandom_range(0, 7));
            else if (calc_sp < 2 || ($urandom_range(0, 2) == 0 && calc_sp < 20))
                c = CMD_PUSH;
            else
                c = cmd_t'($urandom_range(1, 6));
            send_item(c, random_value());
        end
    endtask

    initial
    begin
        errors       = 0;
        cycle_count  = 0;
        calc_sp      = 0;
        hold_results = 0;
        hold_cycles  = 0;
        rst_n        = 1'b0;
        push         = 1'b0;
        in_item      = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_full_stack();
        test_random();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("rpn_stack_calculator test passed");
        else
            $display("rpn_stack_calculator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rpn_pkg.sv
sv/rpn_front.sv
sv/rpn_back.sv
sv/rpn_stack_calculator.sv
test/tb_rpn_stack_calculator.sv
